// ===== rtl/sipx_pkg.sv =====
// types, character codes and defaults shared by the uri host and port extractor
`timescale 1ns / 1ps

package sipx_pkg;

    // default longest uri, in characters
    localparam int MAX_URI_LEN_DEF = 1024;

    // widest legal port value
    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    // delimiter, blank and digit codes
    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // scan states
    typedef enum logic [1:0] {
        SCAN_NONE = 2'd0,
        SCAN_USER = 2'd1,
        SCAN_HOST = 2'd2,
        SCAN_PORT = 2'd3
    } t_scan;

    // one input character
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_req;

    // one extraction result
    typedef struct packed {
        logic [9:0]  host_offset;
        logic [10:0] host_length;
        logic [15:0] port_number;
        logic        parse_error;
    } t_out_req;

endpackage

// ===== rtl/sipx_in_reg.sv =====
// input register holding one character request for the scan stage
`timescale 1ns / 1ps

module sipx_in_reg
    import sipx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in_req i_in_req,
    output logic    o_in_stall,
    input  logic    i_step,
    output logic    o_valid,
    output t_in_req o_req
);

    logic    r_valid;
    t_in_req r_req;
    logic    w_load;

    // hold off the sender only while the held request cannot move on
    assign o_in_stall = r_valid && !i_step;
    assign w_load     = i_in_valid && !o_in_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req <= i_in_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== rtl/sipx_scan.sv =====
// scan state machine: delimiter tracking, host trimming and port accumulation
`timescale 1ns / 1ps

module sipx_scan
    import sipx_pkg::*;
#(
    parameter int MAX_URI_LEN = MAX_URI_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_req  i_req,
    output t_out_req o_res
);

    localparam int CNT_W = $clog2(MAX_URI_LEN + 1);
    localparam int POS_W = $clog2(MAX_URI_LEN);
    localparam logic [CNT_W-1:0] MAX_POS = CNT_W'(MAX_URI_LEN);

    t_scan            r_state, n_state;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_first, n_first;
    logic [POS_W-1:0] r_last, n_last;
    logic             r_seen, n_seen;
    logic [POS_W-1:0] r_hstart, n_hstart;
    logic [CNT_W-1:0] r_hlen, n_hlen;
    logic [15:0]      r_port, n_port;
    logic             r_fin, n_fin;
    logic             r_err, n_err;

    logic [7:0]       w_c;
    logic             w_delim;
    logic             w_closer;
    logic             w_blank;
    logic             w_digit;
    logic [7:0]       w_dval;
    logic [19:0]      w_pnext;
    logic [POS_W-1:0] w_cur;
    logic [CNT_W-1:0] w_seglen;
    logic [CNT_W-1:0] w_nseglen;
    logic [POS_W-1:0] w_fstart;
    logic [CNT_W-1:0] w_flen;
    logic [31:0]      w_off32;
    logic [31:0]      w_len32;

    // character classes
    assign w_c      = i_req.char_in;
    assign w_closer = (w_c == CH_SEMI) || (w_c == CH_GT);
    assign w_delim  = w_closer || (w_c == CH_AT) || (w_c == CH_COLON);
    assign w_blank  = (w_c == CH_SPACE) || (w_c == CH_TAB);
    assign w_digit  = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_dval   = w_c - CH_ZERO;
    assign w_pnext  = {4'b0, r_port} * 20'd10 + 20'(w_dval[3:0]);
    assign w_cur    = r_pos[POS_W-1:0];

    // trimmed length of the open segment, before and after this character
    assign w_seglen  = CNT_W'(r_last) - CNT_W'(r_first) + CNT_W'(1);
    assign w_nseglen = CNT_W'(n_last) - CNT_W'(n_first) + CNT_W'(1);

    // next state and captured fields for one character
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_first  = r_first;
        n_last   = r_last;
        n_seen   = r_seen;
        n_hstart = r_hstart;
        n_hlen   = r_hlen;
        n_port   = r_port;
        n_fin    = r_fin;
        n_err    = r_err;
        if (!r_fin && !r_err) begin
            if (r_pos >= MAX_POS) begin
                n_err = 1'b1;
            end else if (w_delim) begin
                case (r_state)
                    SCAN_NONE: begin
                        if (w_c == CH_COLON) begin
                            n_state = SCAN_USER;
                            n_seen  = 1'b0;
                            n_first = '0;
                            n_last  = '0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    SCAN_USER: begin
                        if (w_c == CH_AT) begin
                            n_state = SCAN_HOST;
                            n_seen  = 1'b0;
                            n_first = '0;
                            n_last  = '0;
                        end else begin
                            n_hstart = r_seen ? r_first : '0;
                            n_hlen   = r_seen ? w_seglen : '0;
                            if (w_c == CH_COLON) begin
                                n_state = SCAN_PORT;
                            end else begin
                                n_fin = 1'b1;
                            end
                        end
                    end
                    SCAN_HOST: begin
                        if (w_c == CH_AT) begin
                            n_err = 1'b1;
                        end else begin
                            n_hstart = r_seen ? r_first : '0;
                            n_hlen   = r_seen ? w_seglen : '0;
                            if (w_c == CH_COLON) begin
                                n_state = SCAN_PORT;
                            end else begin
                                n_fin = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (w_closer) begin
                            n_fin = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                endcase
            end else if (r_state == SCAN_USER || r_state == SCAN_HOST) begin
                if (!w_blank) begin
                    if (!r_seen) begin
                        n_first = w_cur;
                        n_seen  = 1'b1;
                    end
                    n_last = w_cur;
                end
            end else if (r_state == SCAN_PORT && w_digit) begin
                if (w_pnext > 20'(PORT_MAX)) begin
                    n_port = PORT_MAX;
                    n_err  = 1'b1;
                end else begin
                    n_port = w_pnext[15:0];
                end
            end
        end
        if (r_pos < MAX_POS) begin
            n_pos = r_pos + CNT_W'(1);
        end
    end

    // host seen at the end of an unclosed user or host segment
    always_comb begin
        w_fstart = n_hstart;
        w_flen   = n_hlen;
        if (!n_fin && !n_err && (n_state == SCAN_USER || n_state == SCAN_HOST)) begin
            w_fstart = n_seen ? n_first : '0;
            w_flen   = n_seen ? w_nseglen : '0;
        end
    end

    // result fields, valid on the last character
    assign w_off32 = 32'(w_fstart);
    assign w_len32 = 32'(w_flen);
    always_comb begin
        o_res.host_offset = (w_flen != '0) ? w_off32[9:0] : 10'd0;
        o_res.host_length = w_len32[10:0];
        o_res.port_number = n_port;
        o_res.parse_error = n_err;
    end

    // state registers, back to the start after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_req.last_char)) begin
            r_state  <= SCAN_NONE;
            r_pos    <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_seen   <= 1'b0;
            r_hstart <= '0;
            r_hlen   <= '0;
            r_port   <= '0;
            r_fin    <= 1'b0;
            r_err    <= 1'b0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_first  <= n_first;
            r_last   <= n_last;
            r_seen   <= n_seen;
            r_hstart <= n_hstart;
            r_hlen   <= n_hlen;
            r_port   <= n_port;
            r_fin    <= n_fin;
            r_err    <= n_err;
        end
    end

endmodule

// ===== rtl/sipx_out_reg.sv =====
// result register feeding the output channel
`timescale 1ns / 1ps

module sipx_out_reg
    import sipx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_out_req i_res,
    output logic     o_free,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     r_valid;
    t_out_req r_res;

    // room when empty or being taken this cycle
    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_req   = r_res;

endmodule

// ===== rtl/sip_uri_host_port_extractor_top.sv =====
// Top level of the SIP URI host and port extractor.
// The last character passes from the input register through the scan logic
// into the result register, which drives the output channel.
// Throughput: one character per cycle; the input stalls only while a
// finished result waits in the result register and the next held character
// is a last character. Synchronous active-low reset empties both registers.
`timescale 1ns / 1ps

module sip_uri_host_port_extractor_top
    import sipx_pkg::*;
#(
    parameter int MAX_URI_LEN = MAX_URI_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     w_held_valid;
    t_in_req  w_held_req;
    logic     w_out_free;
    logic     w_step;
    t_out_req w_res;

    // a held character moves on unless its result has nowhere to go
    assign w_step = w_held_valid && (!w_held_req.last_char || w_out_free);

    sipx_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_step     (w_step),
        .o_valid    (w_held_valid),
        .o_req      (w_held_req)
    );

    sipx_scan #(
        .MAX_URI_LEN (MAX_URI_LEN)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (w_held_req),
        .o_res   (w_res)
    );

    sipx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step && w_held_req.last_char),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/sipx_checker.sv =====
// port-level checks for the extractor and their binding to the top level
`timescale 1ns / 1ps

module sipx_port_checks
    import sipx_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input t_in_req  i_in_req,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_req
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the input stalls only behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    // an empty host reports offset zero
    a_empty_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.host_length == 11'd0) |->
            (o_out_req.host_offset == 10'd0))
        else $error("empty host with nonzero offset");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

endmodule

bind sip_uri_host_port_extractor_top sipx_port_checks u_sipx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_req    (i_in_req),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

// ===== dv/sipx_checker.sv =====
// channel monitor, result predictor and comparator for the uri host and port extractor
`timescale 1ns / 1ps

module sipx_checker
    import sipx_pkg::*;
#(
    parameter int MAX_URI_LEN = MAX_URI_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    input  logic     i_in_stall,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending
);

    // predicted scan state
    t_scan       scan_st;
    logic [10:0] char_pos;
    logic [9:0]  seg_first;
    logic [9:0]  seg_last;
    logic        seg_seen;
    logic [9:0]  host_start;
    logic [10:0] host_len;
    logic [15:0] port_acc;
    logic        scan_done;
    logic        scan_err;

    // results predicted but not yet seen on the output channel
    t_out_req expected_results[$];
    int       mismatch_count = 0;
    bit       produced;
    t_out_req predicted;
    t_out_req oldest;

    assign o_fail_count = mismatch_count;

    task automatic start_segment();
        seg_seen  = 1'b0;
        seg_first = '0;
        seg_last  = '0;
    endtask

    task automatic clear_scan();
        scan_st    = SCAN_NONE;
        char_pos   = '0;
        start_segment();
        host_start = '0;
        host_len   = '0;
        port_acc   = '0;
        scan_done  = 1'b0;
        scan_err   = 1'b0;
    endtask

    // current segment becomes the host
    task automatic capture_host();
        if (seg_seen) begin
            host_start = seg_first;
            host_len   = {1'b0, seg_last} - {1'b0, seg_first} + 11'd1;
        end else begin
            host_start = '0;
            host_len   = '0;
        end
    endtask

    // advance the scan by one character, building a result on the last one
    task automatic scan_char(input logic [7:0] ch, input logic last,
                             output bit has_result, output t_out_req res);
        bit closer;
        int value;
        closer     = (ch == CH_SEMI) || (ch == CH_GT);
        has_result = 1'b0;
        res        = '0;
        if (!scan_done && !scan_err) begin
            if (char_pos >= MAX_URI_LEN) begin
                scan_err = 1'b1;
            end else if (ch inside {CH_AT, CH_SEMI, CH_GT, CH_COLON}) begin
                // delimiter handling per scan state
                case (scan_st)
                    SCAN_NONE: begin
                        if (ch == CH_COLON) begin
                            scan_st = SCAN_USER;
                            start_segment();
                        end else begin
                            scan_err = 1'b1;
                        end
                    end
                    SCAN_USER: begin
                        if (ch == CH_AT) begin
                            scan_st = SCAN_HOST;
                            start_segment();
                        end else if (ch == CH_COLON) begin
                            capture_host();
                            scan_st = SCAN_PORT;
                        end else begin
                            capture_host();
                            scan_done = 1'b1;
                        end
                    end
                    SCAN_HOST: begin
                        if (ch == CH_AT) begin
                            scan_err = 1'b1;
                        end else if (ch == CH_COLON) begin
                            capture_host();
                            scan_st = SCAN_PORT;
                        end else begin
                            capture_host();
                            scan_done = 1'b1;
                        end
                    end
                    default: begin
                        if (closer) scan_done = 1'b1;
                        else scan_err = 1'b1;
                    end
                endcase
            end else if (scan_st == SCAN_USER || scan_st == SCAN_HOST) begin
                // track first and last non-blank of the segment
                if (ch != CH_SPACE && ch != CH_TAB) begin
                    if (!seg_seen) begin
                        seg_first = char_pos[9:0];
                        seg_seen  = 1'b1;
                    end
                    seg_last = char_pos[9:0];
                end
            end else if (scan_st == SCAN_PORT && ch >= CH_ZERO && ch <= CH_NINE) begin
                // decimal accumulate with saturation
                value = int'(port_acc) * 10 + int'(ch - CH_ZERO);
                if (value > int'(PORT_MAX)) begin
                    value    = int'(PORT_MAX);
                    scan_err = 1'b1;
                end
                port_acc = value[15:0];
            end
        end
        if (char_pos < MAX_URI_LEN) char_pos = char_pos + 11'd1;

        if (last) begin
            if (!scan_done && !scan_err && (scan_st == SCAN_USER || scan_st == SCAN_HOST))
                capture_host();
            res.host_offset = (host_len != 0) ? host_start : '0;
            res.host_length = host_len;
            res.port_number = port_acc;
            res.parse_error = scan_err;
            has_result      = 1'b1;
            clear_scan();
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h",
                             $time, i_out_req);
                    mismatch_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("host_offset", oldest.host_offset, i_out_req.host_offset);
                    check_field("host_length", oldest.host_length, i_out_req.host_length);
                    check_field("port_number", oldest.port_number, i_out_req.port_number);
                    check_field("parse_error", oldest.parse_error, i_out_req.parse_error);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_char(i_in_req.char_in, i_in_req.last_char, produced, predicted);
                if (produced) expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
// top of the uri host and port extractor testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import sipx_pkg::*;

    typedef logic [7:0] t_text[$];

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 600;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_req = '0;
    logic     in_stall;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_req out_req;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    sip_uri_host_port_extractor_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    sipx_checker check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_req     (in_req),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result-side stall bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // one character request, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{char_in: ch, last_char: last};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_uri(input t_text t);
        foreach (t[i]) send_char(t[i], i == t.size() - 1);
    endtask

    task automatic text_of(input string s, output t_text t);
        t = {};
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 3))
            0:       return CH_AT;
            1:       return CH_SEMI;
            2:       return CH_GT;
            default: return CH_COLON;
        endcase
    endfunction

    // any byte except a delimiter, blanks now and then
    function automatic logic [7:0] plain_char(input bit allow_blank);
        logic [7:0] c;
        if (allow_blank && $urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
        do c = 8'($urandom_range(0, 255)); while (c inside {CH_AT, CH_SEMI, CH_GT, CH_COLON});
        return c;
    endfunction

    // mostly well-formed uris with random content, some noise and broken ones
    task automatic make_uri(output t_text t);
        int kind;
        t    = {};
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 12))
                t.push_back($urandom_range(0, 3) == 0 ? pick_delim() : 8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) t.push_back(plain_char(1'b1));
            t.push_back(CH_COLON);
            repeat ($urandom_range(0, 6)) t.push_back(plain_char(1'b1));
            if ($urandom_range(0, 3) != 0) begin
                t.push_back(CH_AT);
                repeat ($urandom_range(0, 8)) t.push_back(plain_char(1'b1));
            end
            if ($urandom_range(0, 2) != 0) begin
                t.push_back(CH_COLON);
                repeat ($urandom_range(0, 6))
                    t.push_back($urandom_range(0, 5) == 0 ? plain_char(1'b1)
                                                         : CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 2) == 0) begin
                t.push_back($urandom_range(0, 1) ? CH_SEMI : CH_GT);
                repeat ($urandom_range(0, 4)) t.push_back(8'($urandom_range(0, 255)));
            end
            // broken: a stray delimiter somewhere
            if (kind == 2) t.insert($urandom_range(0, t.size()), pick_delim());
        end
    endtask

    initial begin
        t_text uri;
        int    sent;

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: no delimiter, top and bottom byte values
        uri = {};
        uri.push_back(8'hFF);
        send_uri(uri);
        uri = {};
        uri.push_back(8'h00);
        send_uri(uri);
        // delimiter in the none state
        text_of("@", uri);
        send_uri(uri);
        // empty host closed by '>'
        text_of(":@>", uri);
        send_uri(uri);
        // user straight to port, then '@' in the port
        text_of(":a:7@", uri);
        send_uri(uri);
        // second '@' in the host
        text_of(":@@", uri);
        send_uri(uri);
        // port overflow just past the maximum, with a skipped byte
        text_of(":h:6553", uri);
        uri.push_back(8'h00);
        uri.push_back(CH_ZERO + 8'd6);
        send_uri(uri);
        // blank trimming, closer in the user part, ignored tail
        text_of(": x\t;q", uri);
        send_uri(uri);
        // end in the port state without a closer
        text_of(":@ host :65535", uri);
        send_uri(uri);

        // host near the top offset, then digits past the longest uri
        uri = {CH_COLON, CH_AT};
        repeat (MAX_URI_LEN_DEF - 4) uri.push_back(CH_SPACE);
        uri.push_back(8'h78);
        uri.push_back(CH_COLON);
        uri.push_back(CH_ZERO + 8'd5);
        uri.push_back(CH_ZERO + 8'd6);
        send_uri(uri);

        // random uris, with idle-free stretches and a quiet tail
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            idle_on = (sent < RANDOM_CHARS - 300) && ((sent / 250) % 3 != 2);
            make_uri(uri);
            send_uri(uri);
            sent += uri.size();
        end
        idle_on = 1'b0;

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
